// ===== hdl/lz77bd_pkg.sv =====
`timescale 1ns / 1ps

package lz77bd_pkg;

  localparam logic [4:0]  OPS_PER_DESC = 5'd30;
  localparam logic [5:0]  MATCH_BIAS   = 6'd3;
  localparam logic [13:0] DIST_MASK    = 14'h3FFF;
  localparam logic [3:0]  DIST_BITS    = 4'd14;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clear;     // stream start: drop pointer, count and length
    logic       hdr;       // merge the input byte into the declared length
    logic [1:0] hdr_idx;
    logic       lit;       // emit the input byte
    logic       mstart;    // decode a match word and set up the copy
    logic [1:0] n;
    logic [7:0] mhi;
    logic       rd;        // read one history byte
    logic       wr;        // emit the byte read last
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic target_zero;
    logic reach;
    logic copy_last;
  } dp_stat_t;

endpackage

// ===== hdl/lz77_block_descriptor_decompressor.sv =====
`timescale 1ns / 1ps
// Header, descriptor and match-high bytes are taken one per transaction; a literal is
// in the output register in the cycle after its transaction.
// A match copies through the single-port history memory, a read then a write
// per byte, and takes no new input until the copy is done.
// Reset (rst_n low, synchronous) clears the parser, write pointer, counts and
// output valid flag; history contents and the copy source are not cleared.

module lz77_block_descriptor_decompressor #(
  parameter int HISTORY_DEPTH = 16384
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] stream_start
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] stream_done
);
  import lz77bd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lz77bd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

  lz77bd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hdl/lz77bd_ctrl.sv =====
`timescale 1ns / 1ps

module lz77bd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tuser,
  output lz77bd_pkg::dp_cmd_t  cmd,
  input  lz77bd_pkg::dp_stat_t stat
);
  import lz77bd_pkg::*;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_DESC,
    ST_OP,
    ST_MLO,
    ST_DONE,
    ST_RD,
    ST_WR
  } state_t;

  state_t      state_r, state_nxt, eff_state;
  logic [1:0]  byte_idx_r, byte_idx_nxt, eff_idx;
  logic [31:0] desc_r, desc_nxt;
  logic [4:0]  ops_left_r, ops_left_nxt, ops_dec;
  logic [7:0]  mhi_r, mhi_nxt;
  logic        in_state;
  logic        acc;
  logic        op_is_match;
  state_t      finish_state;

  always_comb begin
    in_state = (state_r == ST_HEADER) || (state_r == ST_DESC) || (state_r == ST_OP) ||
               (state_r == ST_MLO) || (state_r == ST_DONE);
  end

  assign in_tready = in_state && stat.out_free;
  assign acc       = in_tvalid && in_tready;

  // A stream start overrides whatever input phase the parser was in; it is not taken during a match copy.
  assign eff_state   = in_tuser ? ST_HEADER : state_r;
  assign eff_idx     = in_tuser ? 2'd0 : byte_idx_r;
  assign op_is_match = desc_r[5'(ops_left_r + 5'd1)];
  assign ops_dec     = ops_left_r - 5'd1;

  always_comb begin
    if (stat.reach) begin
      finish_state = ST_DONE;
    end else if (ops_dec == 5'd0) begin
      finish_state = ST_DESC;
    end else begin
      finish_state = ST_OP;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    byte_idx_nxt = byte_idx_r;
    desc_nxt     = desc_r;
    ops_left_nxt = ops_left_r;
    mhi_nxt      = mhi_r;
    cmd          = '0;
    cmd.hdr_idx  = eff_idx;
    cmd.n        = desc_r[1:0];
    cmd.mhi      = mhi_r;
    cmd.clear    = acc && in_tuser;
    if (acc) begin
      unique case (eff_state)
        ST_HEADER: begin
          cmd.hdr      = 1'b1;
          byte_idx_nxt = eff_idx + 2'd1;
          if (eff_idx == 2'd3) begin
            desc_nxt  = '0;
            state_nxt = stat.target_zero ? ST_DONE : ST_DESC;
          end else begin
            state_nxt = ST_HEADER;
          end
        end
        ST_DESC: begin
          desc_nxt     = {desc_r[23:0], in_tdata};
          byte_idx_nxt = byte_idx_r + 2'd1;
          if (byte_idx_r == 2'd3) begin
            ops_left_nxt = OPS_PER_DESC;
            state_nxt    = ST_OP;
          end
        end
        ST_OP: begin
          if (!op_is_match) begin
            cmd.lit      = 1'b1;
            ops_left_nxt = ops_dec;
            state_nxt    = finish_state;
          end else begin
            mhi_nxt   = in_tdata;
            state_nxt = ST_MLO;
          end
        end
        ST_MLO: begin
          cmd.mstart = 1'b1;
          state_nxt  = ST_RD;
        end
        default: begin
          state_nxt = ST_DONE;
        end
      endcase
    end else if (state_r == ST_RD) begin
      cmd.rd    = 1'b1;
      state_nxt = ST_WR;
    end else if ((state_r == ST_WR) && stat.out_free) begin
      cmd.wr = 1'b1;
      if (stat.copy_last) begin
        ops_left_nxt = ops_dec;
        state_nxt    = finish_state;
      end else begin
        state_nxt = ST_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HEADER;
      byte_idx_r <= '0;
      desc_r     <= '0;
      ops_left_r <= '0;
      mhi_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      byte_idx_r <= byte_idx_nxt;
      desc_r     <= desc_nxt;
      ops_left_r <= ops_left_nxt;
      mhi_r      <= mhi_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The copy sequence never takes input.
  a_no_input_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_WR) |-> !in_tready)
    else $error("input taken during a match copy");

  // A match word always leads straight into a history read.
  a_mstart_to_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mstart |=> (state_r == ST_RD))
    else $error("match start not followed by a read");

  // Every operation phase has operations left to do.
  a_ops_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OP || state_r == ST_MLO) |-> (ops_left_r != 5'd0))
    else $error("operation phase with no operations left");
`endif

endmodule

// ===== hdl/lz77bd_dp.sv =====
`timescale 1ns / 1ps

module lz77bd_dp #(
  parameter int HISTORY_DEPTH = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lz77bd_pkg::dp_cmd_t  cmd,
  output lz77bd_pkg::dp_stat_t stat,
  input  logic [7:0]           in_byte,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser
);
  import lz77bd_pkg::*;

  localparam int PTR_W = $clog2(HISTORY_DEPTH);

  logic [7:0]       history_mem [HISTORY_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_inc;
  logic [PTR_W-1:0] src_r, src_inc, src_calc;
  logic [PTR_W:0]   src_diff;
  logic [31:0]      cnt_r, cnt_inc;
  logic [31:0]      target_r, target_nxt, hdr_base, hdr_merge;
  logic [5:0]       len_r, len_calc;
  logic [7:0]       rd_data_r;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;
  logic             out_done_r;
  logic [15:0]      word;
  logic [13:0]      dist_mask;
  logic [14:0]      match_dist;
  logic             emit;
  logic [7:0]       emit_byte;

  assign stat.out_free    = !out_valid_r || out_tready;
  assign stat.copy_last   = (len_r == 6'd1);

  assign hdr_base  = cmd.clear ? 32'd0 : target_r;
  assign hdr_merge = hdr_base | (32'(in_byte) << {cmd.hdr_idx, 3'b000});
  assign stat.target_zero = (hdr_merge == 32'd0);

  always_comb begin
    if (cmd.hdr) begin
      target_nxt = hdr_merge;
    end else begin
      target_nxt = hdr_base;
    end
  end

  // The output count saturates instead of wrapping.
  assign cnt_inc     = (&cnt_r) ? cnt_r : cnt_r + 32'd1;
  assign stat.reach  = (cnt_inc >= target_r);

  assign wp_inc  = (wp_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
  assign src_inc = (src_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : src_r + PTR_W'(1);

  // Match word: distance in the low 14-n bits, length in the bits above.
  assign word       = {cmd.mhi, in_byte};
  assign dist_mask  = DIST_MASK >> cmd.n;
  assign match_dist = {1'b0, word[13:0] & dist_mask} + 15'd1;
  assign len_calc   = 6'(word >> (DIST_BITS - {2'b00, cmd.n})) + MATCH_BIAS;
  assign src_diff   = {1'b0, wp_r} - (PTR_W+1)'(match_dist);
  assign src_calc   = src_diff[PTR_W] ? PTR_W'(src_diff + (PTR_W+1)'(HISTORY_DEPTH))
                                      : src_diff[PTR_W-1:0];

  assign emit      = cmd.lit || cmd.wr;
  assign emit_byte = cmd.lit ? in_byte : rd_data_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      history_mem[wp_r] <= emit_byte;
    end
    if (cmd.rd) begin
      rd_data_r <= history_mem[src_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      cnt_r       <= '0;
      target_r    <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      target_r <= target_nxt;
      if (cmd.clear) begin
        wp_r  <= '0;
        cnt_r <= '0;
      end else if (emit) begin
        wp_r  <= wp_inc;
        cnt_r <= cnt_inc;
      end
      if (cmd.mstart) begin
        len_r <= len_calc;
      end else if (cmd.wr) begin
        len_r <= len_r - 6'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mstart) begin
      src_r <= src_calc;
    end else if (cmd.rd) begin
      src_r <= src_inc;
    end
    if (emit) begin
      out_data_r <= emit_byte;
      out_last_r <= cmd.lit || stat.copy_last;
      out_done_r <= stat.reach;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

`ifndef NO_ASSERTIONS
  // A byte is emitted only into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> stat.out_free)
    else $error("output register overwritten");

  // Copy steps only run while bytes of the match remain.
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.wr) |-> (len_r != 6'd0))
    else $error("copy step with empty length");

  // A decoded match is at least three bytes long.
  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mstart |=> (len_r >= MATCH_BIAS))
    else $error("match shorter than the minimum");

  // The write pointer stays inside the history.
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (PTR_W+1)'(wp_r) < (PTR_W+1)'(HISTORY_DEPTH))
    else $error("write pointer out of range");
`endif

endmodule
